// ----- rtl/core/plist_pkg.sv -----
// Shared types and constants for the positional list engine.
// It depends on nothing. The cell and the top level import it.
`default_nettype none

package plist_pkg;

	// List geometry and field widths.
	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int DATA_W      = 32;
	localparam int POS_W       = 8;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

	// Request action codes. Code 7 is unused and is reported as out of range.
	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_POS   = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_POS   = 3'd5,
		ACT_READ_ALL  = 3'd6
	} act_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CHAIN_IDLE = 2'd0,
		CHAIN_INS  = 2'd1,
		CHAIN_DEL  = 2'd2,
		CHAIN_ROT  = 2'd3
	} chain_op_t;

	// Control word for the chain: for insert and delete, idx is the edit slot;
	// for a rotation it is the tail slot that takes the head entry.
	typedef struct packed {
		chain_op_t                op;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] data;
	} chain_ctrl_t;

	// Read-out sequencer states.
	typedef enum logic [1:0] {
		RD_IDLE = 2'd0,
		RD_EMIT = 2'd1,
		RD_WRAP = 2'd2
	} rd_state_t;

	// Request item.
	typedef struct packed {
		act_t                     action;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	// Result item.
	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] entry_value;
		logic                     is_last;
		logic [LEN_W-1:0]         length;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/positional_list_engine.sv -----
// Top level of the positional list engine: request decode, read-out
// sequencer, result register and the row of list cells. Depends on
// plist_pkg and plist_cell.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  plist_pkg::req_t
//   rsp      out        rsp_valid / rsp_ready  plist_pkg::rsp_t
//
// An edit gives one item; edits follow back to back while the result register
// drains. A read-all first loads no result and then emits the entries in turn,
// as the cell chain rotates the head entry into the result register; when more
// than MAX_RESULTS entries are held, silent rotations of the rest follow to
// restore the order.
// Reset clears the entry count and the sequencer; cell contents are kept.
// A stalled result register stalls request intake and the emitting rotations, but not the silent ones.
`default_nettype none

module positional_list_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire plist_pkg::req_t   req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output plist_pkg::rsp_t        rsp
);
	import plist_pkg::*;

	rd_state_t                rd_state_q, rd_state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [CNT_W-1:0]         rd_left_q, rd_left_d;
	logic [EMIT_W-1:0]        emit_left_q, emit_left_d;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q, rsp_d;
	logic                     rsp_load;
	logic                     out_free;
	logic                     req_fire;
	logic                     rd_start;
	chain_ctrl_t              chain_ctrl;
	logic signed [DATA_W-1:0] entries [CAPACITY];
	logic                     is_full;
	logic                     is_empty;
	logic                     ins_pos_ok;
	logic                     del_pos_ok;
	logic [IDX_W-1:0]         pos_idx;
	logic [IDX_W-1:0]         tail_idx;
	logic [EMIT_W-1:0]        emit_total;

	// Handshake and list status terms.
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign req_fire   = req_valid && req_ready;
	assign rd_start   = req_fire && (req.action == ACT_READ_ALL) && !is_empty;
	assign is_full    = (count_q == CNT_W'(CAPACITY));
	assign is_empty   = (count_q == '0);
	assign ins_pos_ok = (req.position != '0) &&
	                    (req.position <= POS_W'(count_q) + POS_W'(1));
	assign del_pos_ok = (req.position != '0) && (req.position <= POS_W'(count_q));
	assign pos_idx    = IDX_W'(req.position - POS_W'(1));
	assign tail_idx   = IDX_W'(count_q - CNT_W'(1));
	assign emit_total = (POS_W'(count_q) > POS_W'(MAX_RESULTS)) ?
	                    EMIT_W'(MAX_RESULTS) : EMIT_W'(count_q);

	// Next state of the read-out sequencer.
	always_comb begin
		rd_state_d = rd_state_q;
		unique case (rd_state_q)
			RD_IDLE: begin
				if (rd_start) begin
					rd_state_d = RD_EMIT;
				end
			end
			RD_EMIT: begin
				if (out_free && (emit_left_q == EMIT_W'(1))) begin
					rd_state_d = (rd_left_q == CNT_W'(1)) ? RD_IDLE : RD_WRAP;
				end
			end
			RD_WRAP: begin
				if (rd_left_q == CNT_W'(1)) begin
					rd_state_d = RD_IDLE;
				end
			end
			default: begin
				rd_state_d = RD_IDLE;
			end
		endcase
	end

	// Decode, chain control and result contents.
	always_comb begin
		req_ready       = 1'b0;
		rsp_load        = 1'b0;
		count_d         = count_q;
		rd_left_d       = rd_left_q;
		emit_left_d     = emit_left_q;
		chain_ctrl.op   = CHAIN_IDLE;
		chain_ctrl.idx  = '0;
		chain_ctrl.data = entries[0];
		rsp_d           = '0;
		rsp_d.status    = ST_DONE;
		rsp_d.is_last   = 1'b1;
		unique case (rd_state_q)
			RD_IDLE: begin
				req_ready = out_free;
				if (req_valid && out_free) begin
					rsp_load = 1'b1;
					case (req.action) inside
						ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
							if (is_full) begin
								rsp_d.status = ST_FULL;
							end else if ((req.action == ACT_INS_POS) && !ins_pos_ok) begin
								rsp_d.status = ST_RANGE;
							end else begin
								chain_ctrl.op   = CHAIN_INS;
								chain_ctrl.data = req.value;
								if (req.action == ACT_INS_FRONT) begin
									chain_ctrl.idx = '0;
								end else if (req.action == ACT_INS_BACK) begin
									chain_ctrl.idx = IDX_W'(count_q);
								end else begin
									chain_ctrl.idx = pos_idx;
								end
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
							if (is_empty) begin
								rsp_d.status = ST_EMPTY;
							end else if ((req.action == ACT_DEL_POS) && !del_pos_ok) begin
								rsp_d.status = ST_RANGE;
							end else begin
								chain_ctrl.op = CHAIN_DEL;
								if (req.action == ACT_DEL_FRONT) begin
									chain_ctrl.idx = '0;
								end else if (req.action == ACT_DEL_BACK) begin
									chain_ctrl.idx = tail_idx;
								end else begin
									chain_ctrl.idx = pos_idx;
								end
								count_d = count_q - CNT_W'(1);
							end
						end
						ACT_READ_ALL: begin
							if (is_empty) begin
								rsp_d.status = ST_EMPTY;
							end else begin
								rsp_load    = 1'b0;
								rd_left_d   = count_q;
								emit_left_d = emit_total;
							end
						end
						default: begin
							rsp_d.status = ST_RANGE;
						end
					endcase
					rsp_d.length = LEN_W'(count_d);
				end
			end
			RD_EMIT: begin
				if (out_free) begin
					rsp_load          = 1'b1;
					rsp_d.entry_value = entries[0];
					rsp_d.is_last     = (emit_left_q == EMIT_W'(1));
					rsp_d.length      = LEN_W'(count_q);
					chain_ctrl.op     = CHAIN_ROT;
					chain_ctrl.idx    = tail_idx;
					rd_left_d         = rd_left_q - CNT_W'(1);
					emit_left_d       = emit_left_q - EMIT_W'(1);
				end
			end
			RD_WRAP: begin
				chain_ctrl.op  = CHAIN_ROT;
				chain_ctrl.idx = tail_idx;
				rd_left_d      = rd_left_q - CNT_W'(1);
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_state_q  <= RD_IDLE;
			count_q     <= '0;
			rd_left_q   <= '0;
			emit_left_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_state_q  <= rd_state_d;
			count_q     <= count_d;
			rd_left_q   <= rd_left_d;
			emit_left_q <= emit_left_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Row of list cells, slot 0 at the front of the list.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] prev_w;
		logic signed [DATA_W-1:0] next_w;

		if (g == 0) begin : g_head
			assign prev_w = '0;
		end else begin : g_body
			assign prev_w = entries[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = entries[g+1];
		end

		plist_cell u_cell (
			.clk        (clk),
			.slot       (IDX_W'(g)),
			.ctrl       (chain_ctrl),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.entry      (entries[g])
		);
	end

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// No request is taken while a read-out is running.
	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_state_q != RD_IDLE) |-> !req_ready)
		else $error("request accepted during read-out");

	// A read-out never emits more items than rotations remain.
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_state_q == RD_EMIT) |-> ((emit_left_q != '0) &&
		(CNT_W'(emit_left_q) <= rd_left_q)))
		else $error("read-out counters out of step");

	// A read-out leaves the entry count untouched.
	a_read_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_state_q != RD_IDLE) |=> (count_q == $past(count_q)))
		else $error("entry count changed during read-out");

	// Starting a read-out never loads a result in the same cycle.
	a_start_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		rd_start |-> !rsp_load)
		else $error("result loaded when read-out started");

endmodule

`default_nettype wire

// ----- rtl/core/plist_cell.sv -----
// One slot of the list chain: holds a single entry and updates it from its
// neighbors or from the broadcast data. Depends on plist_pkg.
`default_nettype none

module plist_cell (
	input  wire logic                               clk,
	input  wire logic [plist_pkg::IDX_W-1:0]        slot,
	input  wire plist_pkg::chain_ctrl_t             ctrl,
	input  wire logic signed [plist_pkg::DATA_W-1:0] prev_entry,
	input  wire logic signed [plist_pkg::DATA_W-1:0] next_entry,
	output logic signed [plist_pkg::DATA_W-1:0]     entry
);
	import plist_pkg::*;

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] entry_d;

	// Insert opens a gap by taking the front neighbor, delete closes one by
	// taking the back neighbor, and a rotation moves the head to the tail.
	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.op)
			CHAIN_INS: begin
				if (slot == ctrl.idx) begin
					entry_d = ctrl.data;
				end else if (slot > ctrl.idx) begin
					entry_d = prev_entry;
				end
			end
			CHAIN_DEL: begin
				if (slot >= ctrl.idx) begin
					entry_d = next_entry;
				end
			end
			CHAIN_ROT: begin
				if (slot == ctrl.idx) begin
					entry_d = ctrl.data;
				end else if (slot < ctrl.idx) begin
					entry_d = next_entry;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// The entry is payload and needs no reset.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

`default_nettype wire
